[src/dad_pkg.sv]
// shared widths, division constants and calendar helpers for the date adder
package dad_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int CountW = 15;

  localparam int SumW   = 16;  // day of year plus count, up to 33164
  localparam int EraW   = 6;   // 400-year eras, up to 42
  localparam int YoeW   = 9;   // year of era, 0..399
  localparam int DoeW   = 18;  // day of era, 0..146096 before wrap, up to 179200 after add
  localparam int DoyW   = 9;   // march-based day of year, 0..365
  localparam int MpW    = 4;   // march-based month, 0..11
  localparam int YbaseW = 15;  // year plus 400 offset, up to 17199
  localparam int T5W    = 11;  // 153 * mp + 2 and 5 * doy + 2

  localparam int LatencyCycles = 11;

  localparam logic [YbaseW-1:0] EraYears    = YbaseW'(400);
  localparam logic [YbaseW-1:0] YearShift   = YbaseW'(399);
  localparam logic [DoeW-1:0]   EraDays     = DoeW'(146097);
  localparam logic [DoeW-1:0]   DaysPerYear = DoeW'(365);
  localparam logic [DoeW-1:0]   DaysJan1    = DoeW'(306);
  localparam logic [DoeW-1:0]   CentDays1   = DoeW'(36524);
  localparam logic [DoeW-1:0]   CentDays2   = DoeW'(73048);
  localparam logic [DoeW-1:0]   CentDays3   = DoeW'(109572);
  localparam logic [YearW-1:0]  Hundred     = YearW'(100);
  localparam logic [T5W-1:0]    MonthSpan   = T5W'(153);
  localparam logic [T5W-1:0]    MonthStep   = T5W'(5);
  localparam logic [T5W-1:0]    MonthRound  = T5W'(2);
  localparam logic [MpW-1:0]    MarchBias   = MpW'(3);
  localparam logic [MpW-1:0]    JanBias     = MpW'(9);
  localparam logic [MpW-1:0]    JanIndex    = MpW'(10);
  localparam logic [MonthW-1:0] MonthMar    = MonthW'(3);
  localparam logic [MonthW-1:0] MonthFeb    = MonthW'(2);

  // reciprocals: floor(x / c) == (x * ceil(2^k / c)) >> k with k = bits(x) + bits(c)
  localparam int Div100YK = 21;
  localparam logic [14:0] Recip100Y = 15'((2**Div100YK + 99) / 100);
  localparam int Div400K = 24;
  localparam logic [15:0] Recip400 = 16'((2**Div400K + 399) / 400);
  localparam int Div100SK = 16;
  localparam logic [9:0] Recip100S = 10'((2**Div100SK + 99) / 100);
  localparam int Div1460K = 29;
  localparam logic [18:0] Recip1460 = 19'((2**Div1460K + 1459) / 1460);
  localparam int Div365K = 27;
  localparam logic [18:0] Recip365 = 19'((2**Div365K + 364) / 365);
  localparam int Div153K = 19;
  localparam logic [11:0] Recip153 = 12'((2**Div153K + 152) / 153);
  localparam int Div5K = 14;
  localparam logic [11:0] Recip5 = 12'((2**Div5K + 4) / 5);

  typedef struct packed {
    logic            valid;
    logic            zero;
    logic [EraW-1:0] era;
    logic [DoeW-1:0] doe;
  } dad_serial_t;

  // days of the months before m in a common year; months past december count the whole year
  function automatic logic [DoyW-1:0] cum_days(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd0, 4'd1: r = DoyW'(0);
      4'd2:       r = DoyW'(31);
      4'd3:       r = DoyW'(59);
      4'd4:       r = DoyW'(90);
      4'd5:       r = DoyW'(120);
      4'd6:       r = DoyW'(151);
      4'd7:       r = DoyW'(181);
      4'd8:       r = DoyW'(212);
      4'd9:       r = DoyW'(243);
      4'd10:      r = DoyW'(273);
      4'd11:      r = DoyW'(304);
      4'd12:      r = DoyW'(334);
      default:    r = DoyW'(365);
    endcase
    return r;
  endfunction

  // days from the start of the era to march 1 of year of era yoe
  function automatic logic [DoeW-1:0] yoe_days(input logic [YoeW-1:0] yoe);
    logic [DoeW-1:0] base;
    logic [DoeW-1:0] quad;
    logic [18:0]     cent_prod;
    logic [DoeW-1:0] cent;
    base      = DoeW'(yoe) * DaysPerYear;
    quad      = DoeW'(yoe >> 2);
    cent_prod = 19'(yoe) * 19'(Recip100S);
    cent      = DoeW'(cent_prod[18:Div100SK]);
    return base + quad - cent;
  endfunction

endpackage

[src/dad_to_serial.sv]
// start date and count to a day of era, four register stages
module dad_to_serial (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [dad_pkg::DayW-1:0]   day_i,
  input  logic [dad_pkg::MonthW-1:0] month_i,
  input  logic [dad_pkg::YearW-1:0]  year_i,
  input  logic [dad_pkg::CountW-1:0] count_i,
  output dad_pkg::dad_serial_t       serial_o
);
  import dad_pkg::*;

  // stage a
  logic              a_valid_q;
  logic [YearW-1:0]  a_year_q;
  logic [MonthW-1:0] a_month_q;
  logic [SumW-1:0]   a_sum_q;
  logic [7:0]        a_hund_q, a_hund_d;
  logic [EraW-1:0]   a_era_q, a_era_d;
  logic [28:0]       hund_prod;
  logic [YbaseW-1:0] ysh_in;
  logic [30:0]       era_prod;

  assign hund_prod = 29'(year_i) * 29'(Recip100Y);
  assign a_hund_d  = hund_prod[28:Div100YK];
  assign ysh_in    = YbaseW'(year_i) + YearShift;
  assign era_prod  = 31'(ysh_in) * 31'(Recip400);
  assign a_era_d   = era_prod[Div400K+EraW-1:Div400K];

  // stage b
  logic              b_valid_q;
  logic [SumW-1:0]   b_rem_q, b_rem_d;
  logic [EraW-1:0]   b_era_q;
  logic [YoeW-1:0]   b_yoe_q, b_yoe_d;
  logic [YearW-1:0]  hund_x100;
  logic              leap;
  logic              leap_extra;
  logic [YbaseW-1:0] ysh_b;

  assign hund_x100  = YearW'(a_hund_q) * Hundred;
  assign leap       = (a_year_q[1:0] == 2'b00) &&
                      ((a_year_q != hund_x100) || (a_hund_q[1:0] == 2'b00));
  assign leap_extra = leap && (a_month_q >= MonthMar);
  assign b_rem_d    = a_sum_q + SumW'(cum_days(a_month_q)) + SumW'(leap_extra);
  assign ysh_b      = YbaseW'(a_year_q) + YearShift;
  assign b_yoe_d    = YoeW'(ysh_b - YbaseW'(a_era_q) * EraYears);

  // stage c
  logic            c_valid_q;
  logic [DoeW-1:0] c_doe_q, c_doe_d;
  logic [SumW-1:0] c_rem_q;
  logic [EraW-1:0] c_era_q;

  assign c_doe_d = yoe_days(b_yoe_q) + DaysJan1;

  // stage d: add the count, fold into the next era at most once
  logic            d_valid_q;
  logic            d_zero_q, d_zero_d;
  logic [EraW-1:0] d_era_q, d_era_d;
  logic [DoeW-1:0] d_doe_q, d_doe_d;
  logic [DoeW-1:0] sum_doe;
  logic            wrap;

  assign sum_doe  = c_doe_q + DoeW'(c_rem_q) - DoeW'(1);
  assign wrap     = sum_doe >= EraDays;
  assign d_doe_d  = wrap ? sum_doe - EraDays : sum_doe;
  assign d_era_d  = c_era_q + EraW'(wrap);
  assign d_zero_d = (c_rem_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_year_q  <= year_i;
    a_month_q <= month_i;
    a_sum_q   <= SumW'(day_i) + SumW'(count_i);
    a_hund_q  <= a_hund_d;
    a_era_q   <= a_era_d;
    b_rem_q   <= b_rem_d;
    b_era_q   <= a_era_q;
    b_yoe_q   <= b_yoe_d;
    c_doe_q   <= c_doe_d;
    c_rem_q   <= b_rem_q;
    c_era_q   <= b_era_q;
    d_zero_q  <= d_zero_d;
    d_era_q   <= d_era_d;
    d_doe_q   <= d_doe_d;
  end

  assign serial_o = '{valid: d_valid_q, zero: d_zero_q, era: d_era_q, doe: d_doe_q};

endmodule

[src/dad_from_serial.sv]
// day of era back to day, month and year, six register stages
module dad_from_serial (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dad_pkg::dad_serial_t       serial_i,
  output logic                       valid_o,
  output logic [dad_pkg::DayW-1:0]   day_o,
  output logic [dad_pkg::MonthW-1:0] month_o,
  output logic [dad_pkg::YearW-1:0]  year_o
);
  import dad_pkg::*;

  // stage e: leap-day corrections of the era
  logic            e_valid_q, e_zero_q;
  logic [EraW-1:0] e_era_q;
  logic [DoeW-1:0] e_doe_q;
  logic [6:0]      e_q1460_q, e_q1460_d;
  logic [1:0]      e_cent_q, e_cent_d;
  logic [36:0]     p1460;

  assign p1460     = 37'(serial_i.doe) * 37'(Recip1460);
  assign e_q1460_d = p1460[Div1460K+6:Div1460K];
  assign e_cent_d  = 2'(serial_i.doe >= CentDays1) + 2'(serial_i.doe >= CentDays2) +
                     2'(serial_i.doe >= CentDays3);

  // stage f
  logic            f_valid_q, f_zero_q;
  logic [EraW-1:0] f_era_q;
  logic [DoeW-1:0] f_doe_q, f_ynum_q;

  // stage g: year of era
  logic            g_valid_q, g_zero_q;
  logic [EraW-1:0] g_era_q;
  logic [DoeW-1:0] g_doe_q;
  logic [YoeW-1:0] g_yoe_q, g_yoe_d;
  logic [36:0]     p365;

  assign p365    = 37'(f_ynum_q) * 37'(Recip365);
  assign g_yoe_d = p365[Div365K+YoeW-1:Div365K];

  // stage h: day of year, full year
  logic              h_valid_q, h_zero_q;
  logic [DoyW-1:0]   h_doy_q, h_doy_d;
  logic [YbaseW-1:0] h_ybase_q, h_ybase_d;

  assign h_doy_d   = DoyW'(g_doe_q - yoe_days(g_yoe_q));
  assign h_ybase_d = YbaseW'(g_era_q) * EraYears + YbaseW'(g_yoe_q);

  // stage i: march-based month
  logic              i_valid_q, i_zero_q;
  logic [DoyW-1:0]   i_doy_q;
  logic [YbaseW-1:0] i_ybase_q;
  logic [MpW-1:0]    i_mp_q, i_mp_d;
  logic [T5W-1:0]    doy_x5;
  logic [22:0]       p153;

  assign doy_x5 = T5W'(h_doy_q) * MonthStep + MonthRound;
  assign p153   = 23'(doy_x5) * 23'(Recip153);
  assign i_mp_d = p153[Div153K+MpW-1:Div153K];

  // stage j: start of that month
  logic              j_valid_q, j_zero_q;
  logic [DoyW-1:0]   j_doy_q;
  logic [YbaseW-1:0] j_ybase_q;
  logic [MpW-1:0]    j_mp_q;
  logic [T5W-1:0]    j_t5_q;

  // final arithmetic, registered in the top level
  logic [22:0]       p5;
  logic [DoyW-1:0]   month_start;
  logic [MonthW-1:0] civil_month;
  logic              early;

  assign p5          = 23'(j_t5_q) * 23'(Recip5);
  assign month_start = p5[Div5K+DoyW-1:Div5K];
  assign civil_month = (j_mp_q < JanIndex) ? MonthW'(j_mp_q + MarchBias)
                                           : MonthW'(j_mp_q - JanBias);
  assign early       = (civil_month <= MonthFeb) || j_zero_q;
  assign valid_o     = j_valid_q;
  assign day_o       = j_zero_q ? '0 : DayW'(j_doy_q - month_start + DoyW'(1));
  assign month_o     = j_zero_q ? MonthW'(1) : civil_month;
  assign year_o      = YearW'(j_ybase_q + YbaseW'(early) - EraYears);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
      i_valid_q <= 1'b0;
      j_valid_q <= 1'b0;
    end else begin
      e_valid_q <= serial_i.valid;
      f_valid_q <= e_valid_q;
      g_valid_q <= f_valid_q;
      h_valid_q <= g_valid_q;
      i_valid_q <= h_valid_q;
      j_valid_q <= i_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_zero_q  <= serial_i.zero;
    e_era_q   <= serial_i.era;
    e_doe_q   <= serial_i.doe;
    e_q1460_q <= e_q1460_d;
    e_cent_q  <= e_cent_d;
    f_zero_q  <= e_zero_q;
    f_era_q   <= e_era_q;
    f_doe_q   <= e_doe_q;
    f_ynum_q  <= e_doe_q - DoeW'(e_q1460_q) + DoeW'(e_cent_q);
    g_zero_q  <= f_zero_q;
    g_era_q   <= f_era_q;
    g_doe_q   <= f_doe_q;
    g_yoe_q   <= g_yoe_d;
    h_zero_q  <= g_zero_q;
    h_doy_q   <= h_doy_d;
    h_ybase_q <= h_ybase_d;
    i_zero_q  <= h_zero_q;
    i_doy_q   <= h_doy_q;
    i_ybase_q <= h_ybase_q;
    i_mp_q    <= i_mp_d;
    j_zero_q  <= i_zero_q;
    j_doy_q   <= i_doy_q;
    j_ybase_q <= i_ybase_q;
    j_mp_q    <= i_mp_q;
    j_t5_q    <= T5W'(i_mp_q) * MonthSpan + MonthRound;
  end

endmodule

[src/date_add_days_core.sv]
// top level of the gregorian date adder
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------------------
//  command  | start_i / busy_o  | start_day_i, start_month_i, start_year_i, days_to_add_i
//  result   | done_o strobe     | result_day_o, result_month_o, result_year_o
//
// one transfer in per cycle, one result per transfer
// each result passes the register chain: four stages to a day of a 400-year era,
// six stages back to a date, then the output register
// busy_o stays low, the pipeline takes a command in every cycle
// reset clears only the valid bits, payload registers come up unknown
// the receiver cannot stall, so each stage moves forward every cycle
module date_add_days_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [dad_pkg::DayW-1:0]   start_day_i,
  input  logic [dad_pkg::MonthW-1:0] start_month_i,
  input  logic [dad_pkg::YearW-1:0]  start_year_i,
  input  logic [dad_pkg::CountW-1:0] days_to_add_i,
  output logic                       done_o,
  output logic [dad_pkg::DayW-1:0]   result_day_o,
  output logic [dad_pkg::MonthW-1:0] result_month_o,
  output logic [dad_pkg::YearW-1:0]  result_year_o
);
  import dad_pkg::*;

  logic              accept;
  dad_serial_t       serial;
  logic              conv_valid;
  logic [DayW-1:0]   conv_day;
  logic [MonthW-1:0] conv_month;
  logic [YearW-1:0]  conv_year;

  logic              done_q;
  logic [DayW-1:0]   day_q;
  logic [MonthW-1:0] month_q;
  logic [YearW-1:0]  year_q;

  // no back-pressure anywhere, so a command is never refused
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // forward half: day of year plus count, folded into an era serial
  dad_to_serial u_to_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .day_i    (start_day_i),
    .month_i  (start_month_i),
    .year_i   (start_year_i),
    .count_i  (days_to_add_i),
    .serial_o (serial)
  );

  // back half: era serial to civil date, zero total handled at the end
  dad_from_serial u_from_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .serial_i (serial),
    .valid_o  (conv_valid),
    .day_o    (conv_day),
    .month_o  (conv_month),
    .year_o   (conv_year)
  );

  // output register, the strobe lasts exactly one cycle per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= conv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= conv_day;
    month_q <= conv_month;
    year_q  <= conv_year;
  end

  assign done_o         = done_q;
  assign result_day_o   = day_q;
  assign result_month_o = month_q;
  assign result_year_o  = year_q;

endmodule

[src/dad_port_checker.sv]
// port-level checks for the date adder and their binding
module dad_port_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic [dad_pkg::DayW-1:0]   result_day_o,
  input logic [dad_pkg::MonthW-1:0] result_month_o
);
  import dad_pkg::*;

  logic [LatencyCycles-1:0] acc_q, acc_d;

  assign acc_d = {acc_q[LatencyCycles-2:0], start_i && !busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // one strobe per transfer, at the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == acc_q[LatencyCycles-1])
    else $error("result strobe does not match accepted commands");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_month_o >= MonthW'(1)) && (result_month_o <= MonthW'(12)))
    else $error("result month out of range");

  // a day of zero only comes from a zero total, which lands in january
  a_zero_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_day_o == '0) |-> (result_month_o == MonthW'(1)))
    else $error("day zero outside january");

  a_february: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_day_o > DayW'(29)) |-> (result_month_o != MonthW'(2)))
    else $error("february longer than 29 days");

endmodule

bind date_add_days_core dad_port_checker u_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .result_day_o   (result_day_o),
  .result_month_o (result_month_o)
);
